FILE: hw/rtl/vpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpd_pkg: shared types and constants for the vertex pair dedup block
// Field widths of the corner and result beats, the scan state type and the
// result record handed from the scan engine to the output stage.
// ----------------------------------------------------------------------------
package vpd_pkg;

  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned KEY_W       = 2 * INDEX_W;
  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned TABLE_DEPTH = 1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } scan_state_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               was_inserted;
    logic               overflow;
    logic [COUNT_W-1:0] unique_count;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vpd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpd_in_if: corner channel
// Valid/ready channel carrying one triangle corner per beat.
// ----------------------------------------------------------------------------
interface vpd_in_if;
  import vpd_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] position_index;
  logic [INDEX_W-1:0] texcoord_index;
  logic               new_mesh;

  modport source (output valid, output position_index, output texcoord_index,
                  output new_mesh, input ready);
  modport sink   (input valid, input position_index, input texcoord_index,
                  input new_mesh, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/vpd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpd_out_if: result channel
// Valid/ready channel carrying one slot lookup result per beat.
// ----------------------------------------------------------------------------
interface vpd_out_if;
  import vpd_pkg::*;

  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot;
  logic               was_inserted;
  logic               overflow;
  logic [COUNT_W-1:0] unique_count;

  modport source (output valid, output slot, output was_inserted, output overflow,
                  output unique_count, input ready);
  modport sink   (input valid, input slot, input was_inserted, input overflow,
                  input unique_count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/vpd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vpd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vpd_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpd_scan: pair table scan engine
// Walks the pair table in order, one read per cycle, compares the returned
// entry against the corner key and appends the key on a miss unless full.
// ----------------------------------------------------------------------------
module vpd_scan #(
  parameter int unsigned DEPTH = vpd_pkg::TABLE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  vpd_in_if.sink                        corner,
  output      logic                     res_valid,
  input  wire logic                     res_ready,
  output      vpd_pkg::result_t         res,
  output      logic                     rd_en,
  output      logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic [vpd_pkg::KEY_W-1:0] rd_data,
  output      logic                     wr_en,
  output      logic [$clog2(DEPTH)-1:0] wr_addr,
  output      logic [vpd_pkg::KEY_W-1:0] wr_data
);
  import vpd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  scan_state_t state, state_next;

  logic [KEY_W-1:0] key;
  logic [CW-1:0]    count;
  logic [CW-1:0]    scan_idx;
  logic             rd_pend;
  logic [AW-1:0]    rd_idx;
  logic [AW-1:0]    res_slot;
  logic             res_ins;
  logic             res_ovf;

  logic accept, hit, more, issue, miss, full;

  assign accept = corner.valid && corner.ready;
  assign hit    = (state == ST_SCAN) && rd_pend && (rd_data == key);
  assign more   = scan_idx < count;
  assign issue  = (state == ST_SCAN) && !hit && more;
  assign miss   = (state == ST_SCAN) && !hit && !more && !rd_pend;
  assign full   = count == CW'(DEPTH);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (corner.valid) state_next = ST_SCAN;
      ST_SCAN: if (hit || miss) state_next = ST_DONE;
      ST_DONE: if (res_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    corner.ready = (state == ST_IDLE);
    res_valid    = (state == ST_DONE);
    rd_en        = issue;
    rd_addr      = scan_idx[AW-1:0];
    wr_en        = miss && !full;
    wr_addr      = count[AW-1:0];
    wr_data      = key;
    res.slot         = SLOT_W'(res_slot);
    res.was_inserted = res_ins;
    res.overflow     = res_ovf;
    res.unique_count = COUNT_W'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (accept) begin
        // a new mesh empties the table before this corner is looked up
        if (corner.new_mesh) count <= '0;
      end else if (miss && !full) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= {corner.position_index, corner.texcoord_index};
      scan_idx <= '0;
    end
    if (issue) begin
      scan_idx <= scan_idx + CW'(1);
      rd_idx   <= scan_idx[AW-1:0];
    end
    if (hit) begin
      res_slot <= rd_idx;
      res_ins  <= 1'b0;
      res_ovf  <= 1'b0;
    end else if (miss) begin
      res_slot <= full ? '0 : count[AW-1:0];
      res_ins  <= !full;
      res_ovf  <= full;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vertex_pair_dedup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_pair_dedup: triangle corner to unique pair slot mapper
// Maps (position index, texcoord index) corners onto a table of unique pairs.
// ----------------------------------------------------------------------------
// Usage:
//   corner: one beat per triangle corner (position_index, texcoord_index,
//     new_mesh). new_mesh empties the pair table before the corner is handled.
//   result: one beat per corner with the slot of the pair, was_inserted on an
//     append, overflow on a miss with a full table (slot 0, nothing stored),
//     and unique_count, the number of pairs held after the corner.
//   Scan: the pair table sits in one RAM with one read port, scanned in
//     index order one entry per cycle. One corner is in the scan at a time:
//     the engine hands its result on and returns to idle before it takes
//     the next corner.
//   Reset (rst, synchronous): empties the table by clearing the pair count;
//     no pass over the RAM is needed since only counted entries are read.
//   Stall: a finished result waits in the output register while the next
//     corner is taken and scanned; the scan holds its result only when the
//     output register is still full at its end.
// ----------------------------------------------------------------------------
module vertex_pair_dedup #(
  parameter int unsigned TABLE_DEPTH = vpd_pkg::TABLE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  vpd_in_if.sink    corner,
  vpd_out_if.source result
);
  import vpd_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;

  logic    out_valid;
  result_t out_res;

  // Pair table: one key per slot, written on append, read by the scan.
  vpd_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  vpd_scan #(
    .DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .corner    (corner),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Output register: load when empty or when its beat leaves this cycle.
  assign res_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign result.valid        = out_valid;
  assign result.slot         = out_res.slot;
  assign result.was_inserted = out_res.was_inserted;
  assign result.overflow     = out_res.overflow;
  assign result.unique_count = out_res.unique_count;

endmodule

`default_nettype wire
